/* hdl/boa_pkg.sv */
// ----------------------------------------------------------------------------
// boa_pkg
// shared widths, register indexes, defaults and pipeline control types
// ----------------------------------------------------------------------------
`default_nettype none

package boa_pkg;

  // default grid and box sizes, whole position units
  localparam int GRID_STEP_DEF  = 100;
  localparam int BOX_WIDTH_DEF  = 400;
  localparam int BOX_HEIGHT_DEF = 400;
  localparam int BOX_LENGTH_DEF = 400;

  // field widths
  localparam int POS_W    = 24;
  localparam int VEL_W    = 24;
  localparam int RANGE_W  = 23;
  localparam int WEIGHT_W = 16;

  // internal widths
  localparam int T_W   = POS_W + 1;     // boid minus corner
  localparam int GV_W  = 20;            // grid value, Q.8, box sizes up to 4096
  localparam int IDX_W = 12;            // grid index
  localparam int D_W   = T_W + 1;       // sample offset
  localparam int D2_W  = 52;            // squared length
  localparam int KEY_W = 3 * IDX_W;     // visit order key

  localparam int N_STAGES = 11;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_AVOID_ENABLE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OBSTACLE_X   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OBSTACLE_Y   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OBSTACLE_Z   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_AVOID_RANGE  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_AVOID_WEIGHT = 3'd5;

  localparam logic [RANGE_W-1:0]  RANGE_RST  = 23'd25600;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd6554;

  // stage advance strobes for the per-axis grid search
  typedef struct packed {
    logic sa;
    logic sb;
    logic sc;
  } boa_adv_t;

endpackage

`default_nettype wire

/* hdl/boa_ifs.sv */
// ----------------------------------------------------------------------------
// boa request channels
// valid/ready channels for boid requests and velocity results
// ----------------------------------------------------------------------------
`default_nettype none

interface boa_in_if import boa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] boid_x;
  logic signed [POS_W-1:0] boid_y;
  logic signed [POS_W-1:0] boid_z;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;

  modport source (output valid, boid_x, boid_y, boid_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink   (input valid, boid_x, boid_y, boid_z, vel_x, vel_y, vel_z,
                  output ready);
endinterface

interface boa_out_if import boa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] new_vel_x;
  logic signed [VEL_W-1:0] new_vel_y;
  logic signed [VEL_W-1:0] new_vel_z;
  logic                    avoided;
  logic                    saturated;

  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, avoided, saturated,
                  input ready);
  modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, avoided, saturated,
                  output ready);
endinterface

`default_nettype wire

/* hdl/boa_axis.sv */
// ----------------------------------------------------------------------------
// boa_axis
// nearest grid value and nearest face value along one box axis, three stages
// ----------------------------------------------------------------------------
`default_nettype none

module boa_axis import boa_pkg::*; #(
  parameter int SIZE = BOX_WIDTH_DEF,
  parameter int STEP = GRID_STEP_DEF
) (
  input  wire logic                   clk,
  input  wire boa_adv_t               adv,
  input  wire logic signed [T_W-1:0]  t_i,
  output logic             [GV_W-1:0] f_o,
  output logic             [IDX_W-1:0] fi_o,
  output logic             [GV_W-1:0] b_o,
  output logic             [IDX_W-1:0] bi_o
);

  localparam int LIDX = (SIZE - 1) / STEP;
  localparam int S    = STEP * 256;
  localparam int LQ   = LIDX * S;
  localparam int TC_W = $clog2(LQ + 2);
  localparam int M    = (2 ** TC_W) / S;
  localparam int M_W  = $clog2(M + 2);
  localparam int SW   = $clog2(S + 1);
  localparam int RW   = ((TC_W > SW) ? TC_W : SW) + 1;
  localparam int P_W  = TC_W + M_W;

  // stage a: clamp flags, quotient estimate, face choice
  logic                lo_a, hi_a, bsel_a;
  logic [TC_W-1:0]     tc_a;
  logic [P_W-1:0]      prod_a;
  logic                lo_r, hi_r, bsel_r;
  logic [TC_W-1:0]     tc_r;
  logic [M_W-1:0]      q_r;

  always_comb begin
    lo_a   = (t_i <= T_W'(0));
    hi_a   = (t_i >= T_W'(LQ));
    bsel_a = ($signed({t_i, 1'b0}) > (T_W + 1)'(LQ));
    tc_a   = t_i[TC_W-1:0];
    prod_a = P_W'(tc_a) * P_W'(M);
  end

  always_ff @(posedge clk) begin
    if (adv.sa) begin
      lo_r   <= lo_a;
      hi_r   <= hi_a;
      bsel_r <= bsel_a;
      tc_r   <= tc_a;
      q_r    <= prod_a[P_W-1:TC_W];
    end
  end

  // stage b: remainder with one correction step
  logic [RW-1:0]  r0_b;
  logic           lo_b_r, hi_b_r, bsel_b_r;
  logic [M_W-1:0] q1_r;
  logic [RW-1:0]  r1_r;

  assign r0_b = RW'(tc_r) - RW'(TC_W'(q_r * S));

  always_ff @(posedge clk) begin
    if (adv.sb) begin
      lo_b_r   <= lo_r;
      hi_b_r   <= hi_r;
      bsel_b_r <= bsel_r;
      if (r0_b >= RW'(S)) begin
        q1_r <= q_r + M_W'(1);
        r1_r <= r0_b - RW'(S);
      end else begin
        q1_r <= q_r;
        r1_r <= r0_b;
      end
    end
  end

  // stage c: round to nearest, ties to the lower grid value
  logic             up_c;
  logic [IDX_W-1:0] n_c;

  always_comb begin
    up_c = ({r1_r, 1'b0} > (RW + 1)'(S));
    priority if (lo_b_r) n_c = '0;
    else if (hi_b_r)     n_c = IDX_W'(LIDX);
    else                 n_c = IDX_W'(q1_r) + IDX_W'(up_c);
  end

  always_ff @(posedge clk) begin
    if (adv.sc) begin
      fi_o <= n_c;
      f_o  <= GV_W'(32'(n_c) * S);
      b_o  <= bsel_b_r ? GV_W'(LQ) : '0;
      bi_o <= bsel_b_r ? IDX_W'(LIDX) : '0;
    end
  end

endmodule

`default_nettype wire

/* hdl/boid_obstacle_avoidance.sv */
// ----------------------------------------------------------------------------
// boid_obstacle_avoidance
// nearest box-surface sample search and cross-product steering per boid
// ----------------------------------------------------------------------------
// throughput: one request per cycle unless a stalled output has filled the 11-stage register pipeline
// the nearest surface sample is found in closed form per axis, not by a walk
// a stalled output holds the pipeline; bubbles are squeezed out stage by stage
// reset: synchronous, active low; clears stage valids and loads register defaults
`default_nettype none

module boid_obstacle_avoidance import boa_pkg::*; #(
  parameter int GRID_STEP  = GRID_STEP_DEF,
  parameter int BOX_WIDTH  = BOX_WIDTH_DEF,
  parameter int BOX_HEIGHT = BOX_HEIGHT_DEF,
  parameter int BOX_LENGTH = BOX_LENGTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  boa_in_if.sink                     in_req,
  boa_out_if.source                  out_req,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                       avoid_enable_r;
  logic signed [POS_W-1:0]    obs_x_r, obs_y_r, obs_z_r;
  logic [RANGE_W-1:0]         avoid_range_r;
  logic [WEIGHT_W-1:0]        avoid_weight_r;
  logic [2*RANGE_W-1:0]       r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_enable_r <= 1'b0;
      obs_x_r        <= '0;
      obs_y_r        <= '0;
      obs_z_r        <= '0;
      avoid_range_r  <= RANGE_RST;
      avoid_weight_r <= WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_AVOID_ENABLE: avoid_enable_r <= cfg_wdata[0];
        CFG_OBSTACLE_X:   obs_x_r        <= cfg_wdata[POS_W-1:0];
        CFG_OBSTACLE_Y:   obs_y_r        <= cfg_wdata[POS_W-1:0];
        CFG_OBSTACLE_Z:   obs_z_r        <= cfg_wdata[POS_W-1:0];
        CFG_AVOID_RANGE:  avoid_range_r  <= cfg_wdata[RANGE_W-1:0];
        CFG_AVOID_WEIGHT: avoid_weight_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // squared range is registered from the range register and follows it in the next cycle
  always_ff @(posedge clk) begin
    r2_r <= (2*RANGE_W)'(avoid_range_r) * (2*RANGE_W)'(avoid_range_r);
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or when the next one loads
  // --------------------------------------------------------------------------
  logic [N_STAGES:1] vld_r;
  logic [N_STAGES:1] rdy;

  always_comb begin
    rdy[N_STAGES] = !vld_r[N_STAGES] || out_req.ready;
    for (int k = N_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_req.valid;
      for (int k = 2; k <= N_STAGES; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_req.ready = rdy[1];

  // --------------------------------------------------------------------------
  // stage 1: boid position relative to the obstacle corner
  // --------------------------------------------------------------------------
  logic signed [T_W-1:0]   t1_r [3];
  logic signed [VEL_W-1:0] v1_r [3];
  logic                    en1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      t1_r[0] <= T_W'(in_req.boid_x) - T_W'(obs_x_r);
      t1_r[1] <= T_W'(in_req.boid_y) - T_W'(obs_y_r);
      t1_r[2] <= T_W'(in_req.boid_z) - T_W'(obs_z_r);
      v1_r[0] <= in_req.vel_x;
      v1_r[1] <= in_req.vel_y;
      v1_r[2] <= in_req.vel_z;
      en1_r   <= avoid_enable_r;
    end
  end

  // --------------------------------------------------------------------------
  // stages 2-4: per-axis nearest grid value and nearest face
  // --------------------------------------------------------------------------
  boa_adv_t              adv;
  logic [GV_W-1:0]       f4 [3];
  logic [GV_W-1:0]       b4 [3];
  logic [IDX_W-1:0]      fi4 [3];
  logic [IDX_W-1:0]      bi4 [3];

  assign adv = '{sa: rdy[2], sb: rdy[3], sc: rdy[4]};

  boa_axis #(.SIZE(BOX_WIDTH), .STEP(GRID_STEP)) u_axis_x (
    .clk(clk), .adv(adv), .t_i(t1_r[0]),
    .f_o(f4[0]), .fi_o(fi4[0]), .b_o(b4[0]), .bi_o(bi4[0])
  );

  boa_axis #(.SIZE(BOX_HEIGHT), .STEP(GRID_STEP)) u_axis_y (
    .clk(clk), .adv(adv), .t_i(t1_r[1]),
    .f_o(f4[1]), .fi_o(fi4[1]), .b_o(b4[1]), .bi_o(bi4[1])
  );

  boa_axis #(.SIZE(BOX_LENGTH), .STEP(GRID_STEP)) u_axis_z (
    .clk(clk), .adv(adv), .t_i(t1_r[2]),
    .f_o(f4[2]), .fi_o(fi4[2]), .b_o(b4[2]), .bi_o(bi4[2])
  );

  // relative position and velocity ride alongside the axis units
  logic signed [T_W-1:0]   t2_r [3], t3_r [3], t4_r [3];
  logic signed [VEL_W-1:0] v2_r [3], v3_r [3], v4_r [3];
  logic                    en2_r, en3_r, en4_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      t2_r <= t1_r;
      v2_r <= v1_r;
      en2_r <= en1_r;
    end
    if (rdy[3]) begin
      t3_r <= t2_r;
      v3_r <= v2_r;
      en3_r <= en2_r;
    end
    if (rdy[4]) begin
      t4_r <= t3_r;
      v4_r <= v3_r;
      en4_r <= en3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: offsets from boid to the free and the face sample on each axis
  // --------------------------------------------------------------------------
  logic signed [D_W-1:0]   df5_r [3], db5_r [3];
  logic [IDX_W-1:0]        fi5_r [3], bi5_r [3];
  logic signed [VEL_W-1:0] v5_r [3];
  logic                    en5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int a = 0; a < 3; a++) begin
        df5_r[a] <= $signed({{(D_W-GV_W){1'b0}}, f4[a]}) - D_W'(t4_r[a]);
        db5_r[a] <= $signed({{(D_W-GV_W){1'b0}}, b4[a]}) - D_W'(t4_r[a]);
      end
      fi5_r <= fi4;
      bi5_r <= bi4;
      v5_r  <= v4_r;
      en5_r <= en4_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: squared offsets
  // --------------------------------------------------------------------------
  function automatic logic [D2_W-1:0] sq(input logic signed [D_W-1:0] d);
    logic signed [2*D_W-1:0] p;
    p = (2*D_W)'(d) * (2*D_W)'(d);
    return p[D2_W-1:0];
  endfunction

  logic [D2_W-1:0]         sf6_r [3], sb6_r [3];
  logic signed [D_W-1:0]   df6_r [3], db6_r [3];
  logic [IDX_W-1:0]        fi6_r [3], bi6_r [3];
  logic signed [VEL_W-1:0] v6_r [3];
  logic                    en6_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int a = 0; a < 3; a++) begin
        sf6_r[a] <= sq(df5_r[a]);
        sb6_r[a] <= sq(db5_r[a]);
      end
      df6_r <= df5_r;
      db6_r <= db5_r;
      fi6_r <= fi5_r;
      bi6_r <= bi5_r;
      v6_r  <= v5_r;
      en6_r <= en5_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: three candidates, each with one axis pinned to its nearest face;
  // the key orders candidates as the surface walk would visit them
  // --------------------------------------------------------------------------
  logic [D2_W-1:0]         d2c7_r [3];
  logic [KEY_W-1:0]        key7_r [3];
  logic signed [D_W-1:0]   df7_r [3], db7_r [3];
  logic signed [VEL_W-1:0] v7_r [3];
  logic                    en7_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      d2c7_r[0] <= sb6_r[0] + sf6_r[1] + sf6_r[2];
      d2c7_r[1] <= sf6_r[0] + sb6_r[1] + sf6_r[2];
      d2c7_r[2] <= sf6_r[0] + sf6_r[1] + sb6_r[2];
      key7_r[0] <= {bi6_r[0], fi6_r[1], fi6_r[2]};
      key7_r[1] <= {fi6_r[0], bi6_r[1], fi6_r[2]};
      key7_r[2] <= {fi6_r[0], fi6_r[1], bi6_r[2]};
      df7_r <= df6_r;
      db7_r <= db6_r;
      v7_r  <= v6_r;
      en7_r <= en6_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: nearest candidate, earlier visit wins a tie
  // --------------------------------------------------------------------------
  function automatic logic nearer(input logic [D2_W-1:0] da, input logic [KEY_W-1:0] ka,
                                  input logic [D2_W-1:0] db, input logic [KEY_W-1:0] kb);
    return (da < db) || ((da == db) && (ka < kb));
  endfunction

  logic [1:0]              win8;
  logic signed [D_W-1:0]   bd8_r [3];
  logic [D2_W-1:0]         bd2_8_r;
  logic signed [VEL_W-1:0] v8_r [3];
  logic                    en8_r;

  always_comb begin
    win8 = 2'd0;
    if (nearer(d2c7_r[1], key7_r[1], d2c7_r[0], key7_r[0])) win8 = 2'd1;
    if (nearer(d2c7_r[2], key7_r[2], d2c7_r[win8], key7_r[win8])) win8 = 2'd2;
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int a = 0; a < 3; a++) begin
        bd8_r[a] <= (win8 == 2'(a)) ? db7_r[a] : df7_r[a];
      end
      bd2_8_r <= d2c7_r[win8];
      v8_r    <= v7_r;
      en8_r   <= en7_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: range test and cross-product terms; inside the range every
  // offset fits the velocity width
  // --------------------------------------------------------------------------
  logic signed [VEL_W-1:0]   bd9 [3];
  logic signed [2*VEL_W-1:0] pr9_r [6];
  logic                      ap9_r;
  logic signed [VEL_W-1:0]   v9_r [3];

  always_comb begin
    for (int a = 0; a < 3; a++) bd9[a] = bd8_r[a][VEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      ap9_r    <= en8_r && (D2_W'(r2_r) > bd2_8_r);
      pr9_r[0] <= (2*VEL_W)'(bd9[1]) * (2*VEL_W)'(v8_r[2]);
      pr9_r[1] <= (2*VEL_W)'(bd9[2]) * (2*VEL_W)'(v8_r[1]);
      pr9_r[2] <= (2*VEL_W)'(bd9[2]) * (2*VEL_W)'(v8_r[0]);
      pr9_r[3] <= (2*VEL_W)'(bd9[0]) * (2*VEL_W)'(v8_r[2]);
      pr9_r[4] <= (2*VEL_W)'(bd9[0]) * (2*VEL_W)'(v8_r[1]);
      pr9_r[5] <= (2*VEL_W)'(bd9[1]) * (2*VEL_W)'(v8_r[0]);
      v9_r     <= v8_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: cross product times weight, Q.40
  // --------------------------------------------------------------------------
  localparam int C_W    = 2 * VEL_W + 1;
  localparam int PROD_W = C_W + WEIGHT_W + 1;
  localparam int PW_W   = 64;

  logic signed [C_W-1:0]            c10 [3];
  logic signed [WEIGHT_W:0]         w10;
  logic signed [PROD_W-1:0]         p10 [3];
  logic signed [PW_W-1:0]           pw10_r [3];
  logic                             ap10_r;
  logic signed [VEL_W-1:0]          v10_r [3];

  always_comb begin
    w10    = $signed({1'b0, avoid_weight_r});
    c10[0] = C_W'(pr9_r[0]) - C_W'(pr9_r[1]);
    c10[1] = C_W'(pr9_r[2]) - C_W'(pr9_r[3]);
    c10[2] = C_W'(pr9_r[4]) - C_W'(pr9_r[5]);
    for (int a = 0; a < 3; a++) p10[a] = PROD_W'(c10[a]) * PROD_W'(w10);
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      for (int a = 0; a < 3; a++) pw10_r[a] <= p10[a][PW_W-1:0];
      ap10_r <= ap9_r;
      v10_r  <= v9_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 11: round to Q.16, add, saturate; this is the output register
  // --------------------------------------------------------------------------
  localparam int CORR_W = PW_W - 24;
  localparam int SUM_W  = CORR_W + 1;
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(8388608);

  logic signed [PW_W-1:0]  rnd11 [3];
  logic signed [SUM_W-1:0] sum11 [3];
  logic signed [VEL_W-1:0] nv11 [3];
  logic [2:0]              clip11;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd11[a] = pw10_r[a] + PW_W'(64'sd8388608);
      sum11[a] = SUM_W'(v10_r[a]) + SUM_W'($signed(rnd11[a][PW_W-1:24]));
      clip11[a] = 1'b0;
      priority if (sum11[a] > VMAX) begin
        nv11[a]   = VMAX[VEL_W-1:0];
        clip11[a] = 1'b1;
      end else if (sum11[a] < VMIN) begin
        nv11[a]   = VMIN[VEL_W-1:0];
        clip11[a] = 1'b1;
      end else begin
        nv11[a]   = sum11[a][VEL_W-1:0];
      end
    end
  end

  logic signed [VEL_W-1:0] nv_r [3];
  logic                    avoided_r, saturated_r;

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      if (ap10_r) begin
        nv_r        <= nv11;
        saturated_r <= |clip11;
      end else begin
        nv_r        <= v10_r;
        saturated_r <= 1'b0;
      end
      avoided_r <= ap10_r;
    end
  end

  assign out_req.valid     = vld_r[N_STAGES];
  assign out_req.new_vel_x = nv_r[0];
  assign out_req.new_vel_y = nv_r[1];
  assign out_req.new_vel_z = nv_r[2];
  assign out_req.avoided   = avoided_r;
  assign out_req.saturated = saturated_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !rdy[1] |-> (vld_r == '1) && !out_req.ready)
    else $error("input stalled with a hole in the pipeline");

  a_clip_needs_avoid: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && out_req.saturated |-> out_req.avoided)
    else $error("clip flagged without a correction");

  a_reset_empties: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> vld_r == '0)
    else $error("pipeline holds a request right after reset");

endmodule

`default_nettype wire

/* tb/boid_obstacle_avoidance_tb.sv */
// ----------------------------------------------------------------------------
// boid_obstacle_avoidance_tb
// self-checking bench: a local model of the nearest-sample search predicts
// each new velocity, results are matched in order against the prediction
// queue, under random gaps, output stalls and one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module boid_obstacle_avoidance_tb;
  import boa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    STEP      = GRID_STEP_DEF;
  localparam longint MAX_VEL  = 8388607;
  localparam longint MIN_VEL  = -8388608;
  localparam int    DRAIN_CYC = 3 * N_STAGES;

  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [VEL_W-1:0] vx, vy, vz;
  } boid_t;

  typedef struct {
    logic signed [VEL_W-1:0] vx, vy, vz;
    logic                    avoided;
    logic                    saturated;
  } steer_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  boa_in_if  in_req ();
  boa_out_if out_req ();

  boid_obstacle_avoidance dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req.sink),
    .out_req  (out_req.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the register file
  logic                       sh_enable;
  logic signed [POS_W-1:0]    sh_corner [3];
  logic [RANGE_W-1:0]         sh_range;
  logic [WEIGHT_W-1:0]        sh_weight;

  steer_t expected_steer[$];
  int     error_count = 0;
  int     hold_off    = 0;   // output hold-off, counted down by the ready process
  bit     no_stall    = 0;   // stretch with the receiver always ready
  bit     no_gap      = 0;   // stretch with back-to-back requests

  // clock and timeout
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // last grid value strictly below a box size
  function automatic longint last_grid(longint size);
    return ((size - 1) / STEP) * STEP;
  endfunction

  // nearest surface sample, range test, weighted cross product, saturation
  function automatic steer_t predict_steer(boid_t b);
    longint bp[3], v[3], d[3], best[3], c[3], nv[3];
    longint d2, best_d2, r2, p, corr, li, lj, lk;
    bit have, clip, hit;
    steer_t r;
    bp[0] = longint'(b.px); bp[1] = longint'(b.py); bp[2] = longint'(b.pz);
    v[0]  = longint'(b.vx); v[1]  = longint'(b.vy); v[2]  = longint'(b.vz);
    nv = v;
    have = 0; clip = 0; hit = 0; best_d2 = 0;
    best[0] = 0; best[1] = 0; best[2] = 0;
    li = last_grid(BOX_WIDTH_DEF);
    lj = last_grid(BOX_HEIGHT_DEF);
    lk = last_grid(BOX_LENGTH_DEF);
    if (sh_enable) begin
      // i outermost, k innermost; first sample wins a tie
      for (longint i = 0; i < BOX_WIDTH_DEF; i += STEP)
        for (longint j = 0; j < BOX_HEIGHT_DEF; j += STEP)
          for (longint k = 0; k < BOX_LENGTH_DEF; k += STEP) begin
            if (i == 0 || i == li || j == 0 || j == lj || k == 0 || k == lk) begin
              d[0] = longint'(sh_corner[0]) + i * 256 - bp[0];
              d[1] = longint'(sh_corner[1]) + j * 256 - bp[1];
              d[2] = longint'(sh_corner[2]) + k * 256 - bp[2];
              d2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
              if (!have || d2 < best_d2) begin
                have = 1;
                best_d2 = d2;
                best = d;
              end
            end
          end
      r2 = longint'(sh_range) * longint'(sh_range);
      if (have && r2 > best_d2) begin
        hit = 1;
        c[0] = best[1] * v[2] - best[2] * v[1];
        c[1] = best[2] * v[0] - best[0] * v[2];
        c[2] = best[0] * v[1] - best[1] * v[0];
        for (int a = 0; a < 3; a++) begin
          p = c[a] * longint'(sh_weight);
          // round half up from Q.40 to Q.16
          if (p < 64'sh7FFF_FFFF_FF80_0000) p = p + (64'sd1 <<< 23);
          corr = p >>> 24;
          nv[a] = v[a] + corr;
          if (nv[a] > MAX_VEL) begin
            nv[a] = MAX_VEL; clip = 1;
          end else if (nv[a] < MIN_VEL) begin
            nv[a] = MIN_VEL; clip = 1;
          end
        end
      end
    end
    r.vx = nv[0][VEL_W-1:0];
    r.vy = nv[1][VEL_W-1:0];
    r.vz = nv[2][VEL_W-1:0];
    r.avoided = hit;
    r.saturated = clip;
    return r;
  endfunction

  // receiver: random stalls and hold-offs, long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_req.ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_req.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (no_stall) begin
      out_req.ready <= 1'b1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)      out_req.ready <= 1'b1;
      else if (r < 97) out_req.ready <= 1'b0;
      else             hold_off <= $urandom_range(10, 40);
    end
  end

  // result checker: compare against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_req.valid && out_req.ready) begin
      steer_t e;
      if (expected_steer.size() == 0) begin
        $error("unexpected result: no prediction waiting");
        error_count++;
      end else begin
        e = expected_steer.pop_front();
        if (out_req.new_vel_x !== e.vx) begin
          $error("new_vel_x: expected %0d, got %0d", e.vx, out_req.new_vel_x);
          error_count++;
        end
        if (out_req.new_vel_y !== e.vy) begin
          $error("new_vel_y: expected %0d, got %0d", e.vy, out_req.new_vel_y);
          error_count++;
        end
        if (out_req.new_vel_z !== e.vz) begin
          $error("new_vel_z: expected %0d, got %0d", e.vz, out_req.new_vel_z);
          error_count++;
        end
        if (out_req.avoided !== e.avoided) begin
          $error("avoided: expected %0b, got %0b", e.avoided, out_req.avoided);
          error_count++;
        end
        if (out_req.saturated !== e.saturated) begin
          $error("saturated: expected %0b, got %0b", e.saturated, out_req.saturated);
          error_count++;
        end
      end
    end
  end

  // one request: optional gap, then hold valid until accepted
  task automatic send_boid(boid_t b);
    int gap, r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 50) gap = 0;
    else if (r < 92)      gap = $urandom_range(1, 3);
    else                  gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid  <= 1'b1;
    in_req.boid_x <= b.px;
    in_req.boid_y <= b.py;
    in_req.boid_z <= b.pz;
    in_req.vel_x  <= b.vx;
    in_req.vel_y  <= b.vy;
    in_req.vel_z  <= b.vz;
    do @(posedge clk); while (!in_req.ready);
    expected_steer.push_back(predict_steer(b));
  endtask

  // drop valid and wait until every prediction is matched, then drain
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (expected_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // write all six registers, only while idle
  task automatic load_config(logic en, logic [23:0] ox, logic [23:0] oy,
                             logic [23:0] oz, logic [23:0] rng, logic [15:0] wgt);
    logic [CFG_DATA_W-1:0] val [6];
    logic [CFG_ADDR_W-1:0] idx [6];
    val = '{24'(en), ox, oy, oz, rng, 24'(wgt)};
    idx = '{CFG_AVOID_ENABLE, CFG_OBSTACLE_X, CFG_OBSTACLE_Y, CFG_OBSTACLE_Z,
            CFG_AVOID_RANGE, CFG_AVOID_WEIGHT};
    for (int n = 0; n < 6; n++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[n];
      cfg_wdata <= val[n];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    // registers are masked to their widths
    sh_enable    = en;
    sh_corner[0] = ox;
    sh_corner[1] = oy;
    sh_corner[2] = oz;
    sh_range     = rng[RANGE_W-1:0];
    sh_weight    = wgt;
  endtask

  function automatic logic [23:0] rand24();
    return 24'($urandom);
  endfunction

  // boid near the box, mostly within reach of the avoidance range
  function automatic boid_t near_boid(int spread);
    boid_t b;
    b.px = sh_corner[0] + 24'($signed($urandom_range(0, 2 * spread)) - spread + 200 * 256);
    b.py = sh_corner[1] + 24'($signed($urandom_range(0, 2 * spread)) - spread + 200 * 256);
    b.pz = sh_corner[2] + 24'($signed($urandom_range(0, 2 * spread)) - spread + 200 * 256);
    b.vx = rand24();
    b.vy = rand24();
    b.vz = rand24();
    if ($urandom_range(0, 2) == 0) begin
      // small velocities keep most results unclipped
      b.vx = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      b.vy = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      b.vz = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    end
    return b;
  endfunction

  function automatic boid_t mk_boid(int px, int py, int pz, int vx, int vy, int vz);
    boid_t b;
    b.px = POS_W'(px); b.py = POS_W'(py); b.pz = POS_W'(pz);
    b.vx = VEL_W'(vx); b.vy = VEL_W'(vy); b.vz = VEL_W'(vz);
    return b;
  endfunction

  // reset defaults: avoidance off, velocity passes through
  task automatic test_reset_passthrough();
    sh_enable = 1'b0;
    sh_corner = '{default: '0};
    sh_range  = RANGE_RST;
    sh_weight = WEIGHT_RST;
    send_boid(mk_boid(0, 0, 0, 8388607, -8388608, 12345));
    send_boid(mk_boid(-8388608, 8388607, 100, -1, 0, 1));
    wait_idle();
  endtask

  // corner cases of the search and the arithmetic
  task automatic test_directed();
    load_config(1'b1, 24'd0, 24'd0, 24'd0, 24'd25600, 16'd6554);
    // exactly on a sample: zero offset, correction is zero but applied
    send_boid(mk_boid(0, 0, 0, 65536, -65536, 32768));
    // exactly at range distance: not strictly below, no correction
    send_boid(mk_boid(-25600, 0, 0, 65536, 65536, 65536));
    // just inside range
    send_boid(mk_boid(-25599, 0, 0, 65536, 131072, -65536));
    // tie between two samples, first visited wins
    send_boid(mk_boid(12800, -2560, 0, 65536, -131072, 4000));
    // inside the box: nearest is a face sample
    send_boid(mk_boid(51200, 51200, 51200, 100000, -200000, 300000));
    // far corner of the box
    send_boid(mk_boid(76800 + 100, 76800 - 300, 76800 + 50, -7, 9, 3));
    // extremes of positions and velocities, out of range
    send_boid(mk_boid(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send_boid(mk_boid(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
    wait_idle();
    // full weight, largest range: saturation both ways
    load_config(1'b1, 24'd0, 24'd0, 24'd0, 24'h7FFFFF, 16'hFFFF);
    send_boid(mk_boid(-2000000, 0, 3000000, 8388607, -8388608, 8388607));
    send_boid(mk_boid(3000000, -2000000, 0, -8388608, 8388607, -8388608));
    send_boid(mk_boid(8388607, -8388608, 8388607, 8388607, 8388607, -8388608));
    send_boid(mk_boid(25600, 25600, -100000, -1, 1, -1));
    wait_idle();
    // zero range never applies, zero weight applies with no change
    load_config(1'b1, 24'h800000, 24'h7FFFFF, 24'h800000, 24'd0, 16'd0);
    send_boid(mk_boid(-8388608, 8388607, -8388608, 5, 6, 7));
    wait_idle();
    load_config(1'b1, 24'h800000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 16'd0);
    send_boid(mk_boid(-8388608, 8388607, -8388608, 5, 6, 7));
    send_boid(mk_boid(-8000000, 8000000, -8000000, -8388608, 8388607, 0));
    wait_idle();
  endtask

  // random phases over a spread of settings
  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      logic [23:0] ox, oy, oz, rng;
      logic [15:0] wgt;
      ox = rand24(); oy = rand24(); oz = rand24();
      case (ph)
        0: begin rng = 24'd25600;   wgt = 16'd6554; end
        1: begin rng = 24'h7FFFFF;  wgt = 16'hFFFF; ox = 24'h800000; end
        2: begin rng = 24'd0;       wgt = 16'hFFFF; ox = 24'h7FFFFF; end
        3: begin rng = 24'hFFFFFF;  wgt = 16'd1;    end
        default: begin
          rng = 24'($urandom_range(0, 80000));
          wgt = 16'($urandom);
          if ($urandom_range(0, 1)) rng = rand24();
        end
      endcase
      no_stall = (ph == 3);
      no_gap   = (ph == 4);
      load_config(ph != 5, ox, oy, oz, rng, wgt);
      for (int n = 0; n < 120; n++) begin
        boid_t b;
        if ($urandom_range(0, 9) < 7) begin
          b = near_boid($urandom_range(0, 4) == 0 ? 150 * 256 : 300 * 256);
        end else begin
          b.px = rand24(); b.py = rand24(); b.pz = rand24();
          b.vx = rand24(); b.vy = rand24(); b.vz = rand24();
        end
        send_boid(b);
      end
      wait_idle();
    end
    no_stall = 0;
    no_gap   = 0;
  endtask

  // long output hold-off while requests keep coming: the pipe fills and stalls
  task automatic test_backpressure();
    load_config(1'b1, 24'd0, 24'd0, 24'd0, 24'd40000, 16'd30000);
    hold_off = 200;
    no_gap   = 1;
    for (int n = 0; n < 60; n++) send_boid(near_boid(200 * 256));
    no_gap = 0;
    wait_idle();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_req.valid = 1'b0;
    in_req.boid_x = '0; in_req.boid_y = '0; in_req.boid_z = '0;
    in_req.vel_x  = '0; in_req.vel_y  = '0; in_req.vel_z  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_directed();
    test_random();
    test_backpressure();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
